### rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside of reset.
`define PEW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Check a property on every rising edge, reset included.
`define PEW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`else
`define PEW_ASSERT(lbl, clk, rst_n, prop)
`define PEW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/pew_pkg.sv
`default_nettype none

package pew_pkg;

  // Pixel channel and configuration widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int LINE_W = 3 * PIX_W;  // older grey, newer grey, alpha

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;
  localparam int               MIN_SIZE   = 3;

  // Grey = sum / 3 as (sum * 683) >> 11, exact for sums up to 765
  localparam logic [9:0] GREY_RECIP = 10'd683;
  localparam int         GREY_SHIFT = 11;

  // Gradient sum of squares and the saturation point of the root
  localparam int              SQ_W      = 21;
  localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65025;
  localparam logic [7:0]      SAT_ROOT  = 8'd255;

  typedef struct packed {
    logic busy;
    logic done;
  } pew_sqrt_stat_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_SQUARE = 6'b000100,
    S_START  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_EMIT   = 6'b100000
  } pew_state_e;

endpackage

`default_nettype wire

### rtl/core/pew_ram.sv
`default_nettype none

module pew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/pew_isqrt.sv
`default_nettype none

module pew_isqrt
  import pew_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SQ_W-1:0] value_i,
  output pew_sqrt_stat_t       stat_o,
  output      logic [7:0]      root_o
);

  localparam int               V_W       = 16;
  localparam logic [V_W-1:0]   BIT_FIRST = 16'h4000;
  localparam logic [V_W-1:0]   BIT_LAST  = 16'h0001;

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [V_W-1:0] v_q, v_d;
  logic [V_W-1:0] root_q, root_d;
  logic [V_W-1:0] bit_q, bit_d;
  logic [V_W:0]   trial;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  // One result bit per cycle, restoring recurrence
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      if (value_i >= SAT_LIMIT) begin
        root_d = {8'd0, SAT_ROOT};
        done_d = 1'b1;
      end else begin
        v_d    = value_i[V_W-1:0];
        root_d = '0;
        bit_d  = BIT_FIRST;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d    = v_q - trial[V_W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == BIT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q[7:0];

endmodule

`default_nettype wire

### rtl/core/prewitt_edge_magnitude_unit.sv
// Channel    Direction  Handshake               Payload
// pixel in   input      in_valid_i / in_stall_o red_i green_i blue_i alpha_i
// result     output     out_valid_o/out_stall_i magnitude_o centre_alpha_o last_of_frame_o
// config     input      cfg_we_i                cfg_index_i cfg_data_i
//
// A border pixel passes through accept, then the line-store read and write-back.
// An interior pixel passes through accept, fetch, square, root start, 8 root steps,
// the done flag and the result load; the root steps are skipped when the sum saturates the root.
// The result register holds while out_stall_i is high; the next pixel is taken
// meanwhile, and its result waits in the sequencer until the register frees.
// Reset clears counters and control; line stores hold no valid data and need none.
`default_nettype none

`include "assert_macros.svh"

module prewitt_edge_magnitude_unit
  import pew_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [PIX_W-1:0] red_i,
  input  wire logic [PIX_W-1:0] green_i,
  input  wire logic [PIX_W-1:0] blue_i,
  input  wire logic [PIX_W-1:0] alpha_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [PIX_W-1:0] magnitude_o,
  output      logic [PIX_W-1:0] centre_alpha_o,
  output      logic             last_of_frame_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CWP = CW + 1;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int RWP = RW + 1;

  pew_state_e state_q, state_d;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;

  logic [CWP-1:0] eff_w, w_dec;
  logic [RWP-1:0] eff_h, h_dec;
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;

  logic             in_accept;
  logic [9:0]       grey_sum;
  logic [19:0]      grey_prod;
  logic [PIX_W-1:0] grey_q, alpha_q;

  logic [LINE_W-1:0] line_rdata, line_wdata;
  logic              line_we;
  logic [PIX_W-1:0]  top, mid, up_alpha;

  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] alpha_dly_q;

  logic               interior;
  logic [9:0]         sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [10:0] sx_q, sy_q;
  logic signed [21:0] sxx, syy;
  logic [SQ_W-1:0]    sq_q;

  logic             res_last_q;
  logic [PIX_W-1:0] res_alpha_q;

  logic           sq_start;
  pew_sqrt_stat_t sqrt_stat;
  logic [7:0]     sqrt_root;

  logic             out_valid_q;
  logic [PIX_W-1:0] out_mag_q, out_alpha_q;
  logic             out_last_q;
  logic             out_load;

  // Clamp the frame size to the supported range
  always_comb begin
    if (width_q < CFG_W'(MIN_SIZE)) begin
      eff_w = CWP'(MIN_SIZE);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CWP'(MAX_WIDTH);
    end else begin
      eff_w = CWP'(width_q);
    end
    if (height_q < CFG_W'(MIN_SIZE)) begin
      eff_h = RWP'(MIN_SIZE);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = RWP'(MAX_HEIGHT);
    end else begin
      eff_h = RWP'(height_q);
    end
  end

  assign w_dec  = eff_w - CWP'(1);
  assign h_dec  = eff_h - RWP'(1);
  assign w_last = w_dec[CW-1:0];
  assign h_last = h_dec[RW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Grey conversion by reciprocal multiply
  assign grey_sum  = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  assign grey_prod = 20'(grey_sum) * 20'(GREY_RECIP);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      grey_q  <= grey_prod[GREY_SHIFT+PIX_W-1:GREY_SHIFT];
      alpha_q <= alpha_i;
    end
  end

  // Line store: read at accept, write back in the fetch cycle. The next read
  // is issued no earlier than the cycle after the write, so no forwarding.
  assign top        = line_rdata[3*PIX_W-1:2*PIX_W];
  assign mid        = line_rdata[2*PIX_W-1:PIX_W];
  assign up_alpha   = line_rdata[PIX_W-1:0];
  assign line_we    = (state_q == S_FETCH);
  assign line_wdata = {mid, grey_q, alpha_q};

  pew_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (col_q),
    .wdata_i (line_wdata),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // Prewitt sums on the window plus the fetched column
  assign interior = (col_q >= CW'(2)) && (row_q >= RW'(2));
  assign sx_pos   = 10'(top) + 10'(mid) + 10'(grey_q);
  assign sx_neg   = 10'(win_q[0]) + 10'(win_q[1]) + 10'(win_q[2]);
  assign sy_pos   = 10'(win_q[0]) + 10'(win_q[3]) + 10'(top);
  assign sy_neg   = 10'(win_q[2]) + 10'(win_q[5]) + 10'(grey_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH) begin
      sx_q        <= $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
      sy_q        <= $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
      res_alpha_q <= alpha_dly_q;
      res_last_q  <= (col_q == w_last) && (row_q == h_last);
      win_q[0]    <= win_q[3];
      win_q[1]    <= win_q[4];
      win_q[2]    <= win_q[5];
      win_q[3]    <= top;
      win_q[4]    <= mid;
      win_q[5]    <= grey_q;
      alpha_dly_q <= up_alpha;
    end
  end

  // Sum of squares
  assign sxx = sx_q * sx_q;
  assign syy = sy_q * sy_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SQUARE) begin
      sq_q <= SQ_W'(sxx[SQ_W-1:0]) + SQ_W'(syy[SQ_W-1:0]);
    end
  end

  assign sq_start = (state_q == S_START);

  pew_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_q),
    .stat_o  (sqrt_stat),
    .root_o  (sqrt_root)
  );

  // Advance the pixel sequencer
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = interior ? S_SQUARE : S_IDLE;
      end
      S_SQUARE: state_d = S_START;
      S_START:  state_d = S_WAIT;
      S_WAIT: begin
        if (sqrt_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration, frame position and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= SIZE_RESET;
      height_q    <= SIZE_RESET;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (state_q == S_FETCH) begin
        if (col_q == w_last) begin
          col_q <= '0;
          row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mag_q   <= sqrt_root;
      out_alpha_q <= res_alpha_q;
      out_last_q  <= res_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = out_mag_q;
  assign centre_alpha_o  = out_alpha_q;
  assign last_of_frame_o = out_last_q;

  `PEW_ASSERT(a_fetch_after_accept, clk_i, rst_ni, (state_q == S_FETCH) |-> $past(in_accept))
  `PEW_ASSERT(a_start_when_free, clk_i, rst_ni, sq_start |-> !sqrt_stat.busy)
  `PEW_ASSERT(a_done_while_waiting, clk_i, rst_ni, sqrt_stat.done |-> (state_q == S_WAIT))
  `PEW_ASSERT(a_col_in_frame, clk_i, rst_ni, col_q <= w_last)

endmodule

`default_nettype wire

### sim/prewitt_checker.sv
`timescale 1ns / 1ps

module prewitt_checker
  import pew_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic [PIX_W-1:0] alpha_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [PIX_W-1:0] magnitude_i,
  input  logic [PIX_W-1:0] centre_alpha_i,
  input  logic             last_of_frame_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               mismatch_count_o
);

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic [PIX_W-1:0] centre_alpha;
    logic             last_of_frame;
  } edge_result_t;

  // Predictor state
  logic [PIX_W-1:0] older_row [MAX_WIDTH];
  logic [PIX_W-1:0] newer_row [MAX_WIDTH];
  logic [PIX_W-1:0] alpha_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [6];  // [0..2] column x-2, [3..5] column x-1; top, mid, bottom
  logic [PIX_W-1:0] alpha_held;
  int               col;
  int               row;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  edge_result_t expected_results [$];

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
      alpha_row[i] = '0;
    end
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic int clamp_size(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Build the root one bit at a time, from the top bit down
  function automatic logic [7:0] root_floor_sat(int v);
    logic [7:0] root;
    logic [7:0] trial;
    if (v >= 65025) return 8'd255;
    root = '0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (8'd1 << b);
      if (int'(trial) * int'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  prewitt mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Advance the predictor by one pixel and queue its result, if any
  task automatic advance_pixel(input logic [PIX_W-1:0] r, g, b, a);
    int               w;
    int               h;
    int               grey;
    int               sx;
    int               sy;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] up_alpha;
    edge_result_t     res;
    w    = clamp_size(int'(width_reg), MAX_WIDTH);
    h    = clamp_size(int'(height_reg), MAX_HEIGHT);
    grey = (int'(r) + int'(g) + int'(b)) / 3;
    top      = older_row[col];
    mid      = newer_row[col];
    up_alpha = alpha_row[col];

    if (col >= 2 && row >= 2) begin
      sx = (int'(top) + int'(mid) + grey)
         - (int'(win[0]) + int'(win[1]) + int'(win[2]));
      sy = (int'(win[0]) + int'(win[3]) + int'(top))
         - (int'(win[2]) + int'(win[5]) + grey);
      res.magnitude     = root_floor_sat(sx * sx + sy * sy);
      res.centre_alpha  = alpha_held;
      res.last_of_frame = (col == w - 1) && (row == h - 1);
      expected_results.push_back(res);
    end

    // Shift the window and write the line stores back
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = grey[7:0];
    older_row[col] = mid;
    newer_row[col] = grey[7:0];
    alpha_held     = up_alpha;
    alpha_row[col] = a;

    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  // Watch the channels at each edge: register writes, results, then pixels
  always @(posedge clk_i) begin : watch
    edge_result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win[i] = '0;
      alpha_held = '0;
      col        = 0;
      row        = 0;
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IMAGE_WIDTH) begin
          width_reg = cfg_data_i;
        end else begin
          height_reg = cfg_data_i;
        end
        col = 0;
        row = 0;
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending (magnitude %0d alpha %0d)",
                                    magnitude_i, centre_alpha_i));
        end else begin
          res = expected_results.pop_front();
          if (magnitude_i !== res.magnitude)
            report_mismatch($sformatf("magnitude got %0d expected %0d",
                                      magnitude_i, res.magnitude));
          if (centre_alpha_i !== res.centre_alpha)
            report_mismatch($sformatf("centre_alpha got %0d expected %0d",
                                      centre_alpha_i, res.centre_alpha));
          if (last_of_frame_i !== res.last_of_frame)
            report_mismatch($sformatf("last_of_frame got %b expected %b",
                                      last_of_frame_i, res.last_of_frame));
        end
      end

      if (in_valid_i && !in_stall_i) advance_pixel(red_i, green_i, blue_i, alpha_i);
    end
    pending_o <= expected_results.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pew_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int RANDOM_ITEMS = 1495;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    TEXTURE_RANDOM,
    TEXTURE_SMOOTH,
    TEXTURE_BINARY,
    TEXTURE_DARK
  } texture_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [PIX_W-1:0] red_i       = '0;
  logic [PIX_W-1:0] green_i     = '0;
  logic [PIX_W-1:0] blue_i      = '0;
  logic [PIX_W-1:0] alpha_i     = '0;
  logic             out_stall_i = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [PIX_W-1:0] magnitude_o;
  logic [PIX_W-1:0] centre_alpha_o;
  logic             last_of_frame_o;

  int pending_results;
  int mismatch_count;
  int sent_count = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int stall_left = 0;

  always #4 clk_i = ~clk_i;

  prewitt_edge_magnitude_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .magnitude_o    (magnitude_o),
    .centre_alpha_o (centre_alpha_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  prewitt_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) result_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .alpha_i         (alpha_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .magnitude_i     (magnitude_o),
    .centre_alpha_i  (centre_alpha_o),
    .last_of_frame_i (last_of_frame_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending_results),
    .mismatch_count_o(mismatch_count)
  );

  // Mostly short idle runs, now and then a long one
  function automatic int idle_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int effective_size(int v, int hi);
    return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
  endfunction

  // Stall the result channel in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 99) < 12) begin
      stall_left = idle_length() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Present one pixel, after an optional gap, and hold it until taken
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, a);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    alpha_i    <= a;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Drop valid and wait until every result is out and the block is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(input bit set_w, input logic [CFG_W-1:0] w,
                             input bit set_h, input logic [CFG_W-1:0] h);
    drain();
    if (set_w) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IMAGE_WIDTH;
      cfg_data_i  <= w;
      @(posedge clk_i);
    end
    if (set_h) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IMAGE_HEIGHT;
      cfg_data_i  <= h;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_textured(input texture_e texture);
    logic [PIX_W-1:0] r, g, b, v;
    case (texture)
      TEXTURE_SMOOTH: begin
        r = 8'd120 + 8'($urandom_range(0, 15));
        g = 8'd120 + 8'($urandom_range(0, 15));
        b = 8'd120 + 8'($urandom_range(0, 15));
      end
      TEXTURE_BINARY: begin
        v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r = v;
        g = v;
        b = v;
      end
      TEXTURE_DARK: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      default: begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
      end
    endcase
    send_pixel(r, g, b, 8'($urandom_range(0, 255)));
  endtask

  // Stimulus
  initial begin : stimulus
    int               cur_w;
    int               cur_h;
    int               new_w;
    int               new_h;
    int               eff_w;
    int               eff_h;
    int               count;
    int               first_item;
    int               p;
    int               c;
    int               r;
    bit               set_w;
    bit               set_h;
    logic [PIX_W-1:0] v;
    texture_e         texture;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: the start of the first row at the widest frame
    for (int i = 0; i < 24; i++) send_textured(TEXTURE_RANDOM);

    // Minimum frame with a vertical edge that saturates
    reconfigure(1'b1, 11'd3, 1'b1, 11'd3);
    for (int i = 0; i < 9; i++) begin
      c = i % 3;
      v = (c == 0) ? 8'h00 : ((c == 2) ? 8'hFF : 8'h80);
      send_pixel(v, v, v, (i == 4) ? 8'hFF : 8'h00);
    end
    // Next frame follows the wrap: a horizontal edge, then a partial frame
    for (int i = 0; i < 9; i++) begin
      r = i / 3;
      if (r == 0) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h5A);
      else if (r == 1) send_pixel(8'hFF, 8'h00, 8'h00, 8'hA5);
      else send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
    end
    for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'hFF, 8'h00, 8'h01);
    // Rewrite the same width to restart, then sizes below the minimum
    reconfigure(1'b1, 11'd3, 1'b0, '0);
    reconfigure(1'b1, 11'd0, 1'b1, 11'd2);
    for (int i = 0; i < 9; i++) begin
      v = 8'((i % 3) * 10 + i / 3);
      send_pixel(v, v, v, 8'(i * 29));
    end
    cur_w = 0;
    cur_h = 2;

    // Random frames with random sizes, textures and idling
    first_item = sent_count;
    while (sent_count - first_item < RANDOM_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        new_w = $urandom_range(3, 10);
        new_h = $urandom_range(3, 8);
      end else if (p < 80) begin
        new_w = $urandom_range(11, 40);
        new_h = $urandom_range(3, 5);
      end else if (p < 88) begin
        new_w = $urandom_range(0, 2);
        new_h = $urandom_range(0, 6);
      end else if (p < 94) begin
        new_w = $urandom_range(3, 8);
        new_h = $urandom_range(MAX_HEIGHT + 1, 2047);
      end else begin
        new_w = $urandom_range(MAX_WIDTH + 1, 2047);
        new_h = $urandom_range(3, 6);
      end
      set_w = ($urandom_range(0, 9) != 0);
      set_h = !set_w || ($urandom_range(0, 9) != 0);
      reconfigure(set_w, 11'(new_w), set_h, 11'(new_h));
      // A register left alone keeps its old value
      if (set_w) cur_w = new_w;
      if (set_h) cur_h = new_h;
      eff_w = effective_size(cur_w, MAX_WIDTH);
      eff_h = effective_size(cur_h, MAX_HEIGHT);

      if (eff_w == MAX_WIDTH) begin
        count = $urandom_range(1, 12);
      end else if (eff_h == MAX_HEIGHT) begin
        count = $urandom_range(5, 4 * eff_w);
      end else begin
        count = eff_w * eff_h * $urandom_range(1, 3);
        if ($urandom_range(0, 9) < 3) count = $urandom_range(1, count);
      end
      // Hold the total to the planned number of pixels
      if (count > RANDOM_ITEMS - (sent_count - first_item)) begin
        count = RANDOM_ITEMS - (sent_count - first_item);
      end

      texture   = texture_e'($urandom_range(0, 3));
      gaps_on   = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < count; i++) send_textured(texture);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[prewitt_edge_magnitude_unit] OK");
    end else begin
      $display("[prewitt_edge_magnitude_unit] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("[prewitt_edge_magnitude_unit] ERROR");
    $finish;
  end

endmodule

### prewitt_edge_magnitude_unit.f
+incdir+rtl/core
rtl/core/pew_pkg.sv
rtl/core/pew_ram.sv
rtl/core/pew_isqrt.sv
rtl/core/prewitt_edge_magnitude_unit.sv
sim/prewitt_checker.sv
sim/tb_top.sv
